>>> design/bpct_pkg.sv
`default_nettype none

package bpct_pkg;

  // Table size and field widths.
  localparam int MAX_BOARDS = 16;
  localparam int IDX_W      = $clog2(MAX_BOARDS);
  localparam int KEY_W      = 5;
  localparam int CNT_W      = KEY_W + 1;
  localparam int MANUF_W    = 16;
  localparam int PROD_W     = 8;
  localparam int PART_W     = 6;
  localparam int MASK_W     = 32;
  localparam int BIT_W      = $clog2(MASK_W);
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLAIM   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_KEY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_PART = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic write_en;
    logic step;
    logic emit;
    logic emit_hit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_find;
    logic err;
    logic scan_end;
    logic scan_hit;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> design/bpct_ctrl.sv
`default_nettype none

module bpct_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  bpct_pkg::dp_stat_t stat,
  output bpct_pkg::dp_cmd_t  cmd
);
  import bpct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_find && !stat.err) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.write_en = !stat.err && !stat.is_find;
          cmd.emit     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.scan_hit) begin
          cmd.emit     = 1'b1;
          cmd.emit_hit = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

>>> design/bpct_dp.sv
`default_nettype none

module bpct_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [bpct_pkg::KEY_W-1:0]         cfg_wdata,
  input  wire  [bpct_pkg::REQ_W-1:0]         in_req_type,
  input  wire  [bpct_pkg::KEY_W-1:0]         in_board_key,
  input  wire  [bpct_pkg::KEY_W-1:0]         in_after_key,
  input  wire  [bpct_pkg::MANUF_W-1:0]       in_manufacturer,
  input  wire  [bpct_pkg::PROD_W-1:0]        in_product,
  input  wire  [bpct_pkg::PART_W-1:0]        in_part,
  input  bpct_pkg::dp_cmd_t                  cmd,
  output bpct_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  output logic [bpct_pkg::KEY_W-1:0]         out_found_key,
  output logic [bpct_pkg::STAT_W-1:0]        out_status
);
  import bpct_pkg::*;

  // Board table.
  logic [MANUF_W-1:0] maker_r   [MAX_BOARDS];
  logic [PROD_W-1:0]  product_r [MAX_BOARDS];
  logic [MASK_W-1:0]  claimed_r [MAX_BOARDS];

  logic [KEY_W-1:0]   num_boards_r;

  // Captured request.
  logic [REQ_W-1:0]   req_r;
  logic [KEY_W-1:0]   key_r;
  logic [MANUF_W-1:0] manuf_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PART_W-1:0]  part_r;
  logic [CNT_W-1:0]   idx_r;

  // Result register.
  logic               out_valid_r;
  logic [KEY_W-1:0]   out_found_key_r;
  logic [STAT_W-1:0]  out_status_r;

  logic [KEY_W-1:0]   n_used;
  logic [KEY_W-1:0]   key_m1;
  logic [CNT_W-1:0]   idx_m1;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [BIT_W-1:0]   bit_sel;
  logic               part_bad;
  logic               key_bad;
  logic [STAT_W-1:0]  stat_c;

  // Entries in use, saturated at the table size.
  assign n_used = (num_boards_r > KEY_W'(MAX_BOARDS)) ? KEY_W'(MAX_BOARDS) : num_boards_r;

  assign key_m1  = key_r - KEY_W'(1);
  assign idx_m1  = idx_r - CNT_W'(1);
  assign wr_idx  = key_m1[IDX_W-1:0];
  assign rd_idx  = idx_m1[IDX_W-1:0];
  assign bit_sel = part_r[BIT_W-1:0];

  // Request checks; the key is checked before the part.
  assign part_bad = (part_r > PART_W'(MASK_W - 1));

  always_comb begin
    key_bad = 1'b0;
    stat_c  = STAT_OK;
    case (req_r)
      REQ_LOAD: begin
        key_bad = (key_r == '0) || (key_r > KEY_W'(MAX_BOARDS));
        stat_c  = key_bad ? STAT_BAD_KEY : STAT_OK;
      end
      REQ_FIND: begin
        stat_c = part_bad ? STAT_BAD_PART : STAT_OK;
      end
      default: begin
        key_bad = (key_r == '0) || (key_r > n_used);
        if (key_bad) begin
          stat_c = STAT_BAD_KEY;
        end else if (part_bad) begin
          stat_c = STAT_BAD_PART;
        end
      end
    endcase
  end

  // Status to the controller.
  always_comb begin
    stat.is_find  = (req_r == REQ_FIND);
    stat.err      = (stat_c != STAT_OK);
    stat.scan_end = (idx_r > {1'b0, n_used});
    stat.scan_hit = (maker_r[rd_idx] == manuf_r) && (product_r[rd_idx] == prod_r) &&
                    !claimed_r[rd_idx][bit_sel];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_boards_r <= '0;
    end else if (cfg_we) begin
      num_boards_r <= cfg_wdata;
    end
  end

  // Request capture and scan index.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req_type;
      key_r   <= in_board_key;
      manuf_r <= in_manufacturer;
      prod_r  <= in_product;
      part_r  <= in_part;
      idx_r   <= {1'b0, in_after_key} + CNT_W'(1);
    end else if (cmd.step) begin
      idx_r <= idx_r + CNT_W'(1);
    end
  end

  // ID store; its contents are undefined until loaded.
  always_ff @(posedge clk) begin
    if (cmd.write_en && (req_r == REQ_LOAD)) begin
      maker_r[wr_idx]   <= manuf_r;
      product_r[wr_idx] <= prod_r;
    end
  end

  // Claimed-part masks, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BOARDS; i++) begin
        claimed_r[i] <= '0;
      end
    end else if (cmd.write_en) begin
      if (req_r == REQ_CLAIM) begin
        claimed_r[wr_idx][bit_sel] <= 1'b1;
      end else if (req_r == REQ_RELEASE) begin
        claimed_r[wr_idx][bit_sel] <= 1'b0;
      end
    end
  end

  // Result register: one strobe per request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found_key_r <= cmd.emit_hit ? idx_r[KEY_W-1:0] : '0;
      out_status_r    <= stat_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found_key = out_found_key_r;
  assign out_status    = out_status_r;

endmodule

`default_nettype wire

>>> design/board_part_claim_table_top.sv
`default_nettype none

// Expansion board part-claim table. A request is taken when start is high
// and busy is low; its single result appears for exactly one cycle with
// out_valid high and must be taken in that cycle, since there is no way to
// hold it off. Load, claim and release, and a find with a bad part, go back
// to idle straight after the execute state. Any other find walks the entries
// in use one per cycle from the key after in_after_key, and busy stays high
// until a match is found or the last entry in use has been passed. In
// every case the result is shown in the first cycle that busy is low, and a
// new request may be started in that same cycle. The claimed-part masks are
// cleared by reset; the board IDs are undefined until loaded. num_boards
// may only be written while no request is in flight.
module board_part_claim_table_top (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [bpct_pkg::KEY_W-1:0]         cfg_wdata,
  input  wire                                start,
  output logic                               busy,
  input  wire  [bpct_pkg::REQ_W-1:0]         in_req_type,
  input  wire  [bpct_pkg::KEY_W-1:0]         in_board_key,
  input  wire  [bpct_pkg::KEY_W-1:0]         in_after_key,
  input  wire  [bpct_pkg::MANUF_W-1:0]       in_manufacturer,
  input  wire  [bpct_pkg::PROD_W-1:0]        in_product,
  input  wire  [bpct_pkg::PART_W-1:0]        in_part,
  output logic                               out_valid,
  output logic [bpct_pkg::KEY_W-1:0]         out_found_key,
  output logic [bpct_pkg::STAT_W-1:0]        out_status
);
  import bpct_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  bpct_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Table, checks and result register.
  bpct_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_req_type),
    .in_board_key    (in_board_key),
    .in_after_key    (in_after_key),
    .in_manufacturer (in_manufacturer),
    .in_product      (in_product),
    .in_part         (in_part),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_found_key   (out_found_key),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire
